### design/blist_pkg.sv
// ----------------------------------------------------------------------------
// blist_pkg: shared types and codes for the bounded ordered list
// command and status codes, controller/datapath interface structs
// ----------------------------------------------------------------------------
package blist_pkg;

    localparam logic [2:0] CMD_INS_FRONT = 3'd0;
    localparam logic [2:0] CMD_INS_BACK  = 3'd1;
    localparam logic [2:0] CMD_INS_AT    = 3'd2;
    localparam logic [2:0] CMD_RM_FRONT  = 3'd3;
    localparam logic [2:0] CMD_RM_BACK   = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic init;
        logic step_wr;
        logic final_upd;
        logic result_load;
    } blist_ctl_t;

    // datapath to controller
    typedef struct packed {
        logic act;
        logic more;
    } blist_sts_t;

endpackage

### design/blist_ctrl.sv
// ----------------------------------------------------------------------------
// blist_ctrl: sequencing controller
// accepts a command, steps the shift loop and hands the result to the output
// ----------------------------------------------------------------------------
module blist_ctrl
    import blist_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  blist_sts_t sts,
    output blist_ctl_t ctl
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_INIT  = 6'b000010,
        S_STEP  = 6'b000100,
        S_WRITE = 6'b001000,
        S_FINAL = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_INIT;
                end
            end
            S_INIT:
            begin
                ctl.init   = 1'b1;
                state_next = S_STEP;
            end
            S_STEP:
            begin
                if (sts.act && sts.more)
                    state_next = S_WRITE;
                else
                    state_next = S_FINAL;
            end
            S_WRITE:
            begin
                ctl.step_wr = 1'b1;
                state_next  = S_STEP;
            end
            S_FINAL:
            begin
                ctl.final_upd = 1'b1;
                state_next    = S_DONE;
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    ctl.result_load = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctl.result_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### design/blist_dp.sv
// ----------------------------------------------------------------------------
// blist_dp: list datapath
// entry memory, shift index, count, front/back registers and result register
// ----------------------------------------------------------------------------
module blist_dp
    import blist_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  blist_ctl_t         ctl,
    output blist_sts_t         sts,
    input  logic [2:0]         command,
    input  logic signed [31:0] value,
    input  logic [4:0]         position,
    output logic [1:0]         status,
    output logic [4:0]         size,
    output logic               is_empty,
    output logic signed [31:0] front_value,
    output logic signed [31:0] back_value
);

    localparam int CntW = $clog2(DEPTH + 1);
    localparam int AddrW = $clog2(DEPTH);
    localparam int PosW = (CntW > 5) ? CntW : 5;
    localparam int ExtW = (DATA_WIDTH > 32) ? DATA_WIDTH : 32;

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rdata_reg;

    logic [2:0]            cmd_reg;
    logic [DATA_WIDTH-1:0] word_reg;
    logic [4:0]            pos_reg;
    logic [CntW-1:0]       idx_reg, idx_next;
    logic [CntW-1:0]       count_reg, count_next;
    logic [DATA_WIDTH-1:0] front_reg, back_reg;
    logic [1:0]            st_reg;

    logic [1:0]            status_reg;
    logic [4:0]            size_reg;
    logic                  empty_reg;
    logic [31:0]           front_out_reg, back_out_reg;

    logic                  is_ins, is_rmf, is_rmb;
    logic                  full, range_bad, count_zero;
    logic [1:0]            status_code;
    logic [CntW-1:0]       p_eff;
    logic [CntW-1:0]       rd_idx;
    logic [CntW:0]         idx_plus1;
    logic                  mem_we;
    logic [AddrW-1:0]      waddr;
    logic [DATA_WIDTH-1:0] wdata;
    logic [ExtW-1:0]       value_ext, front_ext, back_ext;
    logic [PosW-1:0]       cnt_wide, pos_wide;

    assign is_ins = (cmd_reg == CMD_INS_FRONT) || (cmd_reg == CMD_INS_BACK)
                 || (cmd_reg == CMD_INS_AT);
    assign is_rmf = (cmd_reg == CMD_RM_FRONT);
    assign is_rmb = (cmd_reg == CMD_RM_BACK);

    assign count_zero = (count_reg == '0);
    assign full       = (count_reg == CntW'(DEPTH));
    assign cnt_wide   = PosW'(count_reg);
    assign pos_wide   = PosW'(pos_reg);
    assign range_bad  = (cmd_reg == CMD_INS_AT) && (pos_wide > cnt_wide);

    always_comb
    begin
        status_code = ST_OK;
        if (is_ins)
        begin
            if (range_bad)
                status_code = ST_RANGE;
            else if (full)
                status_code = ST_FULL;
        end
        else if (is_rmf || is_rmb)
        begin
            if (count_zero)
                status_code = ST_EMPTY;
        end
    end

    always_comb
    begin
        case (cmd_reg)
            CMD_INS_FRONT: p_eff = '0;
            CMD_INS_BACK:  p_eff = count_reg;
            default:       p_eff = CntW'(pos_reg);
        endcase
    end

    assign idx_plus1 = {1'b0, idx_reg} + (CntW + 1)'(1);

    always_comb
    begin
        sts.act  = (status_code == ST_OK) && (is_ins || is_rmf || is_rmb);
        sts.more = 1'b0;
        rd_idx   = idx_reg - CntW'(1);
        if (is_ins)
            sts.more = (idx_reg > p_eff);
        else if (is_rmf)
        begin
            sts.more = (idx_plus1 < {1'b0, count_reg});
            rd_idx   = idx_plus1[CntW-1:0];
        end
        else if (is_rmb)
        begin
            sts.more = (count_reg >= CntW'(2)) && (idx_reg == count_reg);
            rd_idx   = idx_reg - CntW'(2);
        end
    end

    // shift writes move the read word, the final write places the new word
    assign mem_we = (ctl.step_wr && (is_ins || is_rmf))
                 || (ctl.final_upd && sts.act && is_ins);
    assign waddr  = ctl.step_wr ? idx_reg[AddrW-1:0] : p_eff[AddrW-1:0];
    assign wdata  = ctl.step_wr ? rdata_reg : word_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[rd_idx[AddrW-1:0]];
    end

    assign value_ext = ExtW'(value);

    always_comb
    begin
        idx_next = idx_reg;
        if (ctl.init)
            idx_next = is_rmf ? '0 : count_reg;
        else if (ctl.step_wr)
            idx_next = is_rmf ? idx_plus1[CntW-1:0] : idx_reg - CntW'(1);
    end

    always_comb
    begin
        count_next = count_reg;
        if (ctl.final_upd && sts.act)
            count_next = is_ins ? count_reg + CntW'(1) : count_reg - CntW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        if (ctl.load)
        begin
            cmd_reg  <= command;
            word_reg <= value_ext[DATA_WIDTH-1:0];
            pos_reg  <= position;
        end
        if (ctl.step_wr && is_rmf && (idx_reg == '0))
            front_reg <= rdata_reg;
        if (ctl.step_wr && is_rmb)
            back_reg <= rdata_reg;
        if (ctl.final_upd)
        begin
            st_reg <= status_code;
            if (sts.act && is_ins)
            begin
                if (p_eff == '0)
                    front_reg <= word_reg;
                if (p_eff == count_reg)
                    back_reg <= word_reg;
            end
        end
    end

    assign front_ext = ExtW'($signed(front_reg));
    assign back_ext  = ExtW'($signed(back_reg));

    always_ff @(posedge clk)
    begin
        if (ctl.result_load)
        begin
            status_reg    <= st_reg;
            size_reg      <= cnt_wide[4:0];
            empty_reg     <= count_zero;
            front_out_reg <= count_zero ? '0 : front_ext[31:0];
            back_out_reg  <= count_zero ? '0 : back_ext[31:0];
        end
    end

    assign status      = status_reg;
    assign size        = size_reg;
    assign is_empty    = empty_reg;
    assign front_value = front_out_reg;
    assign back_value  = back_out_reg;

endmodule

### design/bounded_ordered_list.sv
// ----------------------------------------------------------------------------
// bounded_ordered_list: ordered list of up to DEPTH signed words
// insert at front, back or position; remove front or back; one result each
// ----------------------------------------------------------------------------
// Each command returns one result with status, new size, empty flag and the
// front and back words (zero when empty). Entries live in a memory with one
// read and one write port; positional moves go through it one entry at a time,
// each in a step state and then a write state. The number of entries moved, n,
// is size - position for an insert, size - 1 for a front removal, 1 for a back
// removal with two or more entries, and 0 otherwise (and for rejected commands).
// A new command is taken while the previous result still waits at the output
// register.
module bounded_ordered_list
    import blist_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         command,
    input  logic signed [31:0] value,
    input  logic [4:0]         position,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         status,
    output logic [4:0]         size,
    output logic               is_empty,
    output logic signed [31:0] front_value,
    output logic signed [31:0] back_value
);

    blist_ctl_t ctl;
    blist_sts_t sts;

    blist_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .ctl       (ctl)
    );

    blist_dp #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .sts         (sts),
        .command     (command),
        .value       (value),
        .position    (position),
        .status      (status),
        .size        (size),
        .is_empty    (is_empty),
        .front_value (front_value),
        .back_value  (back_value)
    );

endmodule

### design/blist_checker.sv
// ----------------------------------------------------------------------------
// blist_checker: port-level checks for the bounded ordered list
// result consistency and output hold while stalled
// ----------------------------------------------------------------------------
module blist_checker
    import blist_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  status,
    input logic [4:0]  size,
    input logic        is_empty,
    input logic [31:0] front_value,
    input logic [31:0] back_value
);

    localparam bit SizeFits = (DEPTH < 32);

    a_size_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && SizeFits |-> (32'(size) <= 32'(DEPTH)))
        else $error("size above depth");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && SizeFits |-> (is_empty == (size == 5'd0)))
        else $error("empty flag disagrees with size");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_empty |-> (front_value == 32'd0) && (back_value == 32'd0))
        else $error("nonzero value while empty");

    a_rm_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_EMPTY) |-> is_empty)
        else $error("empty removal left entries");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(size)
            && $stable(front_value) && $stable(back_value))
        else $error("result changed while stalled");

endmodule

bind bounded_ordered_list blist_checker #(
    .DEPTH (DEPTH)
) u_blist_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .size        (size),
    .is_empty    (is_empty),
    .front_value (front_value),
    .back_value  (back_value)
);

### verif/bounded_ordered_list_test.sv
// ----------------------------------------------------------------------------
// bounded_ordered_list_test: self-checking bench for the bounded ordered list
// a scoreboard keeps its own copy of the list, predicts status, size, empty
// flag and end values for every accepted command, and checks each result in
// order; directed corner cases first, then biased random traffic with bursty
// input, random output stalls, a long output hold-off and full drains
// ----------------------------------------------------------------------------
module bounded_ordered_list_test;
    import blist_pkg::*;

    localparam int CLK_PERIOD   = 12;
    localparam int LIST_DEPTH   = 16;
    localparam int RANDOM_ITEMS = 1100;
    localparam int LONG_HOLD    = 80;
    localparam int DRAIN_CYCLES = 60;
    localparam int CYCLE_LIMIT  = 400000;

    // command codes the block treats as no-ops
    localparam logic [2:0] CMD_SPARE_5 = 3'd5;
    localparam logic [2:0] CMD_SPARE_7 = 3'd7;

    typedef struct {
        logic [1:0]         status;
        logic [4:0]         size;
        logic               is_empty;
        logic signed [31:0] front;
        logic signed [31:0] back;
    } list_result_t;

    class list_scoreboard;
        logic signed [31:0] cells [LIST_DEPTH];
        int unsigned        held;
        list_result_t       expected_q [$];
        int                 errors;
        int                 results_checked;
        int                 commands_taken;
        int                 status_count [4];
        int unsigned        peak_held;

        function new();
            held            = 0;
            errors          = 0;
            results_checked = 0;
            commands_taken  = 0;
            peak_held       = 0;
            foreach (status_count[i])
                status_count[i] = 0;
        endfunction

        function void insert_word(int unsigned pos, logic signed [31:0] word);
            int unsigned i;
            for (i = held; i > pos; i--)
                cells[i] = cells[i - 1];
            cells[pos] = word;
            held++;
        endfunction

        function void note_command(logic [2:0] cmd, logic signed [31:0] word,
                                   logic [4:0] pos);
            logic [1:0]   st;
            list_result_t r;
            int unsigned  i;
            st = ST_OK;
            case (cmd)
                CMD_INS_FRONT:
                    if (held >= LIST_DEPTH) st = ST_FULL;
                    else insert_word(0, word);
                CMD_INS_BACK:
                    if (held >= LIST_DEPTH) st = ST_FULL;
                    else insert_word(held, word);
                CMD_INS_AT:
                    if (pos > held) st = ST_RANGE;
                    else if (held >= LIST_DEPTH) st = ST_FULL;
                    else insert_word(pos, word);
                CMD_RM_FRONT:
                    if (held == 0) st = ST_EMPTY;
                    else
                    begin
                        for (i = 0; i + 1 < held; i++)
                            cells[i] = cells[i + 1];
                        held--;
                    end
                CMD_RM_BACK:
                    if (held == 0) st = ST_EMPTY;
                    else held--;
                default: ;
            endcase
            r.status   = st;
            r.size     = 5'(held);
            r.is_empty = (held == 0);
            r.front    = (held == 0) ? 32'sd0 : cells[0];
            r.back     = (held == 0) ? 32'sd0 : cells[held - 1];
            expected_q.push_back(r);
            commands_taken++;
            status_count[st]++;
            if (held > peak_held)
                peak_held = held;
        endfunction

        function void report_mismatch(string field, logic signed [63:0] want,
                                      logic signed [63:0] got);
            errors++;
            $display("%0t: %s mismatch on result %0d, expected %0d, actual %0d",
                     $time, field, results_checked, want, got);
        endfunction

        function void check_result(list_result_t got);
            list_result_t want;
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, status %0d size %0d front %0d back %0d",
                         $time, got.status, got.size, got.front, got.back);
                return;
            end
            want = expected_q.pop_front();
            results_checked++;
            if (got.status !== want.status)
                report_mismatch("status", want.status, got.status);
            if (got.size !== want.size)
                report_mismatch("size", want.size, got.size);
            if (got.is_empty !== want.is_empty)
                report_mismatch("is_empty", want.is_empty, got.is_empty);
            if (got.front !== want.front)
                report_mismatch("front_value", want.front, got.front);
            if (got.back !== want.back)
                report_mismatch("back_value", want.back, got.back);
        endfunction
    endclass

    logic               clk;
    logic               rst_n      = 1'b0;
    logic               in_valid   = 1'b0;
    logic               in_ready;
    logic [2:0]         command    = CMD_INS_FRONT;
    logic signed [31:0] value      = 32'sd0;
    logic [4:0]         position   = 5'd0;
    logic               out_valid;
    logic               out_ready  = 1'b0;
    logic [1:0]         status;
    logic [4:0]         size;
    logic               is_empty;
    logic signed [31:0] front_value;
    logic signed [31:0] back_value;

    list_scoreboard sb;
    bit             hold_off_request = 1'b0;
    int             holds_done       = 0;
    int             drains_done      = 0;
    int             burst_left       = 0;
    bit             steady_sender    = 1'b0;
    int             cycle_count      = 0;

    bounded_ordered_list #(
        .DEPTH      (LIST_DEPTH),
        .DATA_WIDTH (32)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .command     (command),
        .value       (value),
        .position    (position),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .size        (size),
        .is_empty    (is_empty),
        .front_value (front_value),
        .back_value  (back_value)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: timeout after %0d cycles, %0d results still due",
                 $time, cycle_count, sb.expected_q.size());
        $display("TEST FAILED");
        $finish;
    end

    task automatic send_command(input logic [2:0] cmd, input logic signed [31:0] word,
                                input logic [4:0] pos);
        in_valid <= 1'b1;
        command  <= cmd;
        value    <= word;
        position <= pos;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        sb.note_command(cmd, word, pos);
    endtask

    task automatic pause_sender(input int cycles);
        if (cycles > 0)
        begin
            in_valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    task automatic offer(input logic [2:0] cmd, input logic signed [31:0] word,
                         input logic [4:0] pos);
        send_command(cmd, word, pos);
        if (!steady_sender)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 20);
                pause_sender($urandom_range(1, 8));
            end
            else
                burst_left--;
        end
    endtask

    task automatic wait_until_drained();
        pause_sender(1);
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        drains_done++;
    endtask

    task automatic random_command(input int insert_pct);
        int                 roll;
        int unsigned        cur;
        logic [2:0]         cmd;
        logic signed [31:0] word;
        logic [4:0]         pos;
        cur  = sb.held;
        roll = $urandom_range(0, 99);
        if (roll < 3)
            cmd = 3'(CMD_SPARE_5 + $urandom_range(0, 2));
        else if (roll < 3 + insert_pct)
        begin
            case ($urandom_range(0, 3))
                0:       cmd = CMD_INS_FRONT;
                1:       cmd = CMD_INS_BACK;
                default: cmd = CMD_INS_AT;
            endcase
        end
        else
            cmd = $urandom_range(0, 1) ? CMD_RM_FRONT : CMD_RM_BACK;
        case ($urandom_range(0, 11))
            0:       word = 32'sh7FFFFFFF;
            1:       word = 32'sh80000000;
            2:       word = -32'sd1;
            3:       word = 32'sd0;
            default: word = $urandom;
        endcase
        roll = $urandom_range(0, 9);
        if (roll < 7 || cur >= 31)
            pos = 5'($urandom_range(0, cur));
        else if (roll < 9)
            pos = 5'($urandom_range(cur + 1, (cur + 3 > 31) ? 31 : cur + 3));
        else
            pos = 5'($urandom_range(0, 31));
        offer(cmd, word, pos);
    endtask

    // receiver: stall phases of random density, long hold on request
    initial
    begin
        list_result_t got;
        int           phase_left;
        int           stall_pct;
        phase_left = 0;
        stall_pct  = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid === 1'b1 && out_ready === 1'b1)
            begin
                got.status   = status;
                got.size     = size;
                got.is_empty = is_empty;
                got.front    = front_value;
                got.back     = back_value;
                sb.check_result(got);
            end
            if (hold_off_request)
            begin
                hold_off_request = 1'b0;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                holds_done++;
            end
            if (phase_left == 0)
            begin
                phase_left = $urandom_range(30, 200);
                case ($urandom_range(0, 3))
                    0:       stall_pct = 0;
                    1:       stall_pct = 20;
                    2:       stall_pct = 50;
                    default: stall_pct = 85;
                endcase
            end
            else
                phase_left--;
            out_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    initial
    begin
        int k;
        int random_sent;
        int seg_len;
        int insert_pct;
        sb = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // empty list: removals and out-of-range positions
        offer(CMD_RM_FRONT, 32'sd0, 5'd0);
        offer(CMD_RM_BACK, -32'sd1, 5'd31);
        offer(CMD_INS_AT, 32'sd5, 5'd1);
        offer(CMD_INS_AT, -32'sd1, 5'd31);
        // inserts at every place, extreme words
        offer(CMD_INS_AT, 32'sh7FFFFFFF, 5'd0);
        offer(CMD_INS_FRONT, 32'sh80000000, 5'd0);
        offer(CMD_INS_BACK, -32'sd1, 5'd0);
        offer(CMD_INS_AT, 32'sd0, 5'd3);
        offer(CMD_INS_AT, $urandom, 5'd1);
        offer(CMD_SPARE_5, $urandom, 5'd2);
        offer(CMD_SPARE_7, $urandom, 5'd31);
        offer(CMD_RM_FRONT, 32'sd0, 5'd0);
        offer(CMD_RM_BACK, 32'sd0, 5'd0);
        // fill up, then inserts on a full list
        while (sb.held < LIST_DEPTH)
            offer(CMD_INS_AT, $urandom, 5'($urandom_range(0, sb.held)));
        offer(CMD_INS_FRONT, 32'sd1, 5'd0);
        offer(CMD_INS_BACK, 32'sd2, 5'd0);
        offer(CMD_INS_AT, 32'sd3, 5'd16);
        offer(CMD_INS_AT, 32'sd4, 5'd17);
        wait_until_drained();

        random_sent = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            seg_len       = $urandom_range(10, 60);
            steady_sender = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 2))
                0:       insert_pct = 77;
                1:       insert_pct = 20;
                default: insert_pct = 48;
            endcase
            for (k = 0; k < seg_len && random_sent < RANDOM_ITEMS; k++)
            begin
                if (random_sent == 300)
                    hold_off_request = 1'b1;
                if (random_sent == 700)
                    wait_until_drained();
                random_command(insert_pct);
                random_sent++;
            end
        end

        wait_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.expected_q.size() != 0)
        begin
            sb.errors++;
            $display("%0t: %0d results never arrived", $time, sb.expected_q.size());
        end
        $display("covered %0d commands, %0d results checked in %0d cycles, peak size %0d",
                 sb.commands_taken, sb.results_checked, cycle_count, sb.peak_held);
        $display("status mix: ok %0d, bad position %0d, empty removal %0d, full %0d; %0d holds, %0d drains",
                 sb.status_count[ST_OK], sb.status_count[ST_RANGE],
                 sb.status_count[ST_EMPTY], sb.status_count[ST_FULL],
                 holds_done, drains_done);
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### filelist.f
design/blist_pkg.sv
design/blist_ctrl.sv
design/blist_dp.sv
design/bounded_ordered_list.sv
design/blist_checker.sv
verif/bounded_ordered_list_test.sv
